>>> src/int_to_padded_decimal_chars_defines.svh
// Assertion macros shared by the RTL.
`ifndef INT_TO_PADDED_DECIMAL_CHARS_DEFINES_SVH
`define INT_TO_PADDED_DECIMAL_CHARS_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ITPD_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ITPD_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

>>> src/itpd_pkg.sv
package itpd_pkg;
   localparam int MAX_PAD    = 16;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int CNT_W      = $clog2(MAX_PAD + 2);
   localparam int SHIFT_STEPS = 32;
   localparam int STEPS_PER_STAGE = 4;
   localparam int NUM_STAGES = SHIFT_STEPS / STEPS_PER_STAGE;

   localparam logic [5:0] ZERO_CODE  = 6'd48;
   localparam logic [5:0] MINUS_CODE = 6'd45;

   // One word moving through the conversion pipe.
   typedef struct packed {
      logic        negative;
      logic [4:0]  pad;
      logic [31:0] bin;
      logic [BCD_W-1:0] bcd;
   } conv_type;

   // One double-dabble step: add 3 to digits >= 5, then shift in a bit.
   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic b);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (adj[4*d +: 4] >= 4'd5) adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
      return {adj[BCD_W-2:0], b};
   endfunction
endpackage

>>> src/itpd_stream_if.sv
interface itpd_stream_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/int_to_padded_decimal_chars.sv
`include "int_to_padded_decimal_chars_defines.svh"
// channel | dir | payload
// req     | in  | value[31:0] signed, pad_width[4:0]
// rsp     | out | char_code[5:0], last
// An item passes 8 conversion stages (4 dabble steps each), then a
// serializer emits sign, padding zeros and digits, one char a cycle
// while rsp is ready. One item gives 1 to 17 chars; the serializer sets
// the rate, and the pipe takes further items until its stages are full.
// Reset is synchronous and clears all valid bits; a stall holds each full stage with no empty stage after it.
module int_to_padded_decimal_chars (
   input  logic          clock,
   input  logic          reset,
   itpd_stream_if.sink   req,
   itpd_stream_if.source rsp
);
   import itpd_pkg::*;

   conv_type in_word, cv_word;
   logic     cv_valid, cv_ready;

   // req.data = {value, pad_width}
   always_comb begin
      in_word.negative = req.data[36];
      in_word.bin      = req.data[36] ? (32'd0 - req.data[36:5]) : req.data[36:5];
      in_word.pad      = (req.data[4:0] > 5'(MAX_PAD)) ? 5'(MAX_PAD) : req.data[4:0];
      in_word.bcd      = '0;
   end

   itpd_conv u_conv (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_word,
      .out_valid(cv_valid), .out_ready(cv_ready), .out_word(cv_word)
   );

   // serializer state
   logic             busy_ff;
   logic             sign_ff;
   logic [CNT_W-1:0] zeros_ff;
   logic [3:0]       ndig_ff;
   logic [BCD_W-1:0] bcd_ff;
   logic [3:0]       nd;
   logic [CNT_W-1:0] zc;

   // digit count from top nonzero digit
   always_comb begin
      nd = 4'd1;
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (cv_word.bcd[4*d +: 4] != 4'd0) nd = 4'(d + 1);
      end
      zc = (CNT_W'(cv_word.pad) > CNT_W'(nd)) ? CNT_W'(cv_word.pad) - CNT_W'(nd) : '0;
   end

   logic fire;
   logic last_c;
   logic [5:0] code_c;
   assign fire = busy_ff && rsp.ready;
   assign cv_ready = !busy_ff || (fire && last_c);

   always_comb begin
      if (sign_ff) begin
         code_c = MINUS_CODE;
         last_c = 1'b0;
      end else if (zeros_ff != '0) begin
         code_c = ZERO_CODE;
         last_c = 1'b0;
      end else begin
         code_c = ZERO_CODE + 6'(bcd_ff[4*(NUM_DIGITS-1) +: 4]);
         last_c = (ndig_ff == 4'd1);
      end
   end

   assign rsp.valid = busy_ff;
   assign rsp.data  = {code_c, last_c};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cv_valid && cv_ready) begin
         busy_ff  <= 1'b1;
         sign_ff  <= cv_word.negative;
         zeros_ff <= zc;
         ndig_ff  <= nd;
         // left-align digits so the top nibble is the next one out
         bcd_ff   <= cv_word.bcd << (4 * (NUM_DIGITS - nd));
      end else if (fire) begin
         if (last_c) busy_ff <= 1'b0;
         else if (sign_ff) sign_ff <= 1'b0;
         else if (zeros_ff != '0) zeros_ff <= zeros_ff - 1'b1;
         else begin
            ndig_ff <= ndig_ff - 4'd1;
            bcd_ff  <= {bcd_ff[BCD_W-5:0], 4'd0};
         end
      end
   end

   `ITPD_ASSERT_NXT(a_stall, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data), "rsp word changed under stall")
   `ITPD_ASSERT_IMP(a_digs, clock, reset, busy_ff, ndig_ff != 4'd0, "no digits left")
   `ITPD_ASSERT_IMP(a_take, clock, reset, cv_valid && cv_ready, !busy_ff || fire, "took word while emitting")
endmodule

>>> src/itpd_conv.sv
`include "int_to_padded_decimal_chars_defines.svh"
// Pipelined binary to BCD: four dabble steps per stage; under a stall, empty stages still advance.
module itpd_conv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  itpd_pkg::conv_type   in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output itpd_pkg::conv_type   out_word
);
   import itpd_pkg::*;

   logic     vld_ff [NUM_STAGES];
   conv_type wrd_ff [NUM_STAGES];
   logic     adv    [NUM_STAGES];

   // a stage moves when its slot is empty or drains downstream
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || out_ready;
      for (int s = NUM_STAGES-2; s >= 0; s--) adv[s] = !vld_ff[s] || adv[s+1];
   end
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[NUM_STAGES-1];
   assign out_word  = wrd_ff[NUM_STAGES-1];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      conv_type src, nxt_in;
      logic     src_v;
      if (s == 0) begin : g_first
         assign src = in_word;
         assign src_v = in_valid;
      end else begin : g_rest
         assign src = wrd_ff[s-1];
         assign src_v = vld_ff[s-1];
      end
      always_comb begin
         nxt_in = src;
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            nxt_in.bcd = dabble(nxt_in.bcd, nxt_in.bin[31]);
            nxt_in.bin = {nxt_in.bin[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            vld_ff[s] <= src_v;
         end
         if (adv[s]) wrd_ff[s] <= nxt_in;
      end
   end

   `ITPD_ASSERT_IMP(a_hold, clock, reset, out_valid && !out_ready, !adv[NUM_STAGES-1], "last stage moved while stalled")
   `ITPD_ASSERT_NXT(a_keep, clock, reset, out_valid && !out_ready, out_valid, "stalled word lost")
   `ITPD_ASSERT_IMP(a_acc, clock, reset, in_valid && in_ready, adv[0], "accepted without advance")
endmodule
